FILE: rtl/core/bm3_pkg.sv
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared types, constants and window functions of the 3x3 binary morphology.
// ----------------------------------------------------------------------------
package bm3_pkg;

    localparam int          MAX_WIDTH_DEF = 1024;
    localparam int          Q_DEPTH       = 4;
    localparam int          ROW_W         = 12;
    localparam int          HGT_W         = 13;
    localparam logic [12:0] MAX_HEIGHT    = 13'd4096;
    localparam logic [7:0]  FG_VALUE      = 8'hFF;
    localparam logic [8:0]  KEEP_LEFT     = 9'h0DB;

    typedef enum logic [1:0] {
        MODE_DILATE = 2'd0,
        MODE_ERODE  = 2'd1,
        MODE_OPEN   = 2'd2,
        MODE_CLOSE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MODE   = 2'd2,
        CFG_MASK   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic s1;
        logic direct;
        logic s2ok;
        logic last;
    } t_q_ctl;

    function automatic logic [8:0] push_window(input logic [8:0] win,
                                               input logic [1:0] ls,
                                               input logic       pix);
        push_window = ((win >> 1) & KEEP_LEFT) | {6'd0, ls[1], 2'd0}
                      | {3'd0, ls[0], 5'd0} | {pix, 8'd0};
    endfunction

    function automatic logic apply_element(input logic [8:0] win,
                                           input logic [8:0] mask,
                                           input logic       erode);
        logic [8:0] hit;
        hit = win & mask;
        apply_element = erode ? (hit == mask) : (hit != 9'd0);
    endfunction

endpackage

FILE: rtl/core/binary_morphology_3x3.sv
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// Streaming 3x3 binary dilation, erosion, opening and closing.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one word each; a pixel equal to 255 is
// foreground and tuser marks the first pixel of a frame. The block takes one
// pixel per clock unless the queue or output stalls, and gives at most one
// result per pixel, 0 or 255, for interior positions only (a 1-pixel border
// is dropped for dilation and erosion, 2 pixels for opening and closing);
// tlast marks the result of the frame's final pixel. Each window stage reads
// and rewrites one column of its line store per pixel through a registered
// read port with write forwarding, so an uninterrupted stream runs at one
// pixel per cycle. The user must write width, height, mode and mask only
// while the stream is idle; the block itself does not enforce this.
module binary_morphology_3x3 #(
    parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_value
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_pixel
    output logic        m_axis_tlast
);
    import bm3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = $bits(t_q_ctl) + CW;

    logic [10:0] r_width;
    logic [12:0] r_height;
    t_mode       r_mode;
    logic [8:0]  r_mask;
    logic [10:0] w_nz;
    logic [CW:0] w_eff;
    logic [12:0] h_eff;

    logic          f_valid, f_ready, q_valid, q_ready;
    t_q_ctl        f_ctl;
    logic [CW-1:0] f_col;
    logic [DW-1:0] q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd640;
            r_height <= 13'd480;
            r_mode   <= MODE_DILATE;
            r_mask   <= 9'h1FF;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[10:0];
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                CFG_MASK:   r_mask   <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign w_nz  = (r_width == 11'd0) ? 11'd1 : r_width;
    assign w_eff = (32'(w_nz) > 32'(MAX_WIDTH)) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(w_nz);
    assign h_eff = (r_height == 13'd0) ? 13'd1
                 : (r_height > MAX_HEIGHT) ? MAX_HEIGHT : r_height;

    bm3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_w_eff   (w_eff),
        .i_h_eff   (h_eff),
        .i_mode    (r_mode),
        .i_mask    (r_mask),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_pixel   (s_axis_tdata),
        .i_start   (s_axis_tuser),
        .o_q_valid (f_valid),
        .i_q_ready (f_ready),
        .o_q_ctl   (f_ctl),
        .o_q_col   (f_col)
    );

    bm3_fifo #(
        .DW    (DW),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_ctl, f_col}),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_ready)
    );

    bm3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_mask    (r_mask),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_ctl   (t_q_ctl'(q_data[DW-1:CW])),
        .i_q_col   (q_data[CW-1:0]),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_pixel   (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule

FILE: rtl/core/bm3_fifo.sv
// ----------------------------------------------------------------------------
// bm3_fifo
// Short register queue between the classifying front and the back stage.
// ----------------------------------------------------------------------------
module bm3_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_ready,
    output logic          o_valid,
    output logic [DW-1:0] o_data,
    input  logic          i_pop
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;
    logic          push_ok, pop_ok;

    assign o_ready = (r_cnt != NW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: rtl/core/bm3_front.sv
// ----------------------------------------------------------------------------
// bm3_front
// Pixel intake: raster position, input line store, first window stage.
// ----------------------------------------------------------------------------
module bm3_front #(
    parameter  int MAX_WIDTH = 1024,
    localparam int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CW:0]          i_w_eff,
    input  logic [12:0]          i_h_eff,
    input  bm3_pkg::t_mode       i_mode,
    input  logic [8:0]           i_mask,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_pixel,
    input  logic                 i_start,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output bm3_pkg::t_q_ctl      o_q_ctl,
    output logic [CW-1:0]        o_q_col
);
    import bm3_pkg::*;

    logic [CW-1:0]    r_col, n_col, c_in;
    logic [ROW_W-1:0] r_row, n_row, r_in;
    logic             accept, col_wrap, row_wrap, last_in;

    logic             r_a_vld, r_a_fg, r_a_s1ok, r_a_s2ok, r_a_last;
    logic [CW-1:0]    r_a_col;
    logic [1:0]       r_rd, wr;
    logic [1:0]       r_store [MAX_WIDTH];
    logic [8:0]       r_win, win_new;
    logic             a_adv, s1;

    assign a_adv   = r_a_vld && (!r_a_s1ok || i_q_ready);
    assign o_ready = !r_a_vld || a_adv;
    assign accept  = i_valid && o_ready;

    assign c_in     = i_start ? '0 : r_col;
    assign r_in     = i_start ? '0 : r_row;
    assign col_wrap = ((CW+1)'({1'b0, c_in}) + (CW+1)'(1)) >= i_w_eff;
    assign row_wrap = (HGT_W'(r_in) + HGT_W'(1)) >= i_h_eff;
    assign last_in  = (HGT_W'(r_in) == i_h_eff - HGT_W'(1))
                      && ((CW+1)'({1'b0, c_in}) == i_w_eff - (CW+1)'(1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : r_in + ROW_W'(1);
            end else begin
                n_col = c_in + CW'(1);
                n_row = r_in;
            end
        end
    end

    assign wr      = {r_rd[0], r_a_fg};
    assign win_new = push_window(r_win, r_rd, r_a_fg);
    assign s1      = apply_element(win_new, i_mask,
                                   i_mode == MODE_ERODE || i_mode == MODE_OPEN);

    assign o_q_valid      = r_a_vld && r_a_s1ok;
    assign o_q_ctl.s1     = s1;
    assign o_q_ctl.direct = (i_mode == MODE_DILATE) || (i_mode == MODE_ERODE);
    assign o_q_ctl.s2ok   = r_a_s2ok;
    assign o_q_ctl.last   = r_a_last;
    assign o_q_col        = r_a_col - CW'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_a_vld <= 1'b0;
            r_win   <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_a_vld <= 1'b1;
            end else if (a_adv) begin
                r_a_vld <= 1'b0;
            end
            if (a_adv) begin
                r_win <= win_new;
            end
        end
    end

    // read-modify-write per column; forward a same-column write
    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_store[r_a_col] <= wr;
        end
        if (accept) begin
            r_rd     <= (a_adv && r_a_col == c_in) ? wr : r_store[c_in];
            r_a_fg   <= (i_pixel == FG_VALUE);
            r_a_col  <= c_in;
            r_a_s1ok <= (r_in >= ROW_W'(2)) && (c_in >= CW'(2));
            r_a_s2ok <= (r_in >= ROW_W'(4)) && (c_in >= CW'(4));
            r_a_last <= last_in;
        end
    end

endmodule

FILE: rtl/core/bm3_back.sv
// ----------------------------------------------------------------------------
// bm3_back
// Second window stage for opening and closing, and the output register.
// ----------------------------------------------------------------------------
module bm3_back #(
    parameter  int MAX_WIDTH = 1024,
    localparam int CW        = $clog2(MAX_WIDTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bm3_pkg::t_mode  i_mode,
    input  logic [8:0]      i_mask,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    input  bm3_pkg::t_q_ctl i_q_ctl,
    input  logic [CW-1:0]   i_q_col,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_pixel,
    output logic            o_last
);
    import bm3_pkg::*;

    logic          r_a_vld;
    t_q_ctl        r_a_ctl;
    logic [CW-1:0] r_a_col;
    logic [1:0]    r_rd, wr;
    logic [1:0]    r_store [MAX_WIDTH];
    logic [8:0]    r_win, win_new;
    logic          emit, out_free, a_adv, pop, we, res;
    logic          r_o_vld, r_o_last;
    logic [7:0]    r_o_pix;

    assign emit      = r_a_ctl.direct || r_a_ctl.s2ok;
    assign out_free  = !r_o_vld || i_ready;
    assign a_adv     = r_a_vld && (!emit || out_free);
    assign o_q_ready = !r_a_vld || a_adv;
    assign pop       = i_q_valid && o_q_ready;
    assign we        = a_adv && !r_a_ctl.direct;

    assign wr      = {r_rd[0], r_a_ctl.s1};
    assign win_new = push_window(r_win, r_rd, r_a_ctl.s1);
    assign res     = r_a_ctl.direct ? r_a_ctl.s1
                                    : apply_element(win_new, i_mask, i_mode == MODE_CLOSE);

    assign o_valid = r_o_vld;
    assign o_pixel = r_o_pix;
    assign o_last  = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_win   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            if (pop) begin
                r_a_vld <= 1'b1;
            end else if (a_adv) begin
                r_a_vld <= 1'b0;
            end
            if (we) begin
                r_win <= win_new;
            end
            if (a_adv && emit) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[r_a_col] <= wr;
        end
        if (pop) begin
            r_rd    <= (we && r_a_col == i_q_col) ? wr : r_store[i_q_col];
            r_a_ctl <= i_q_ctl;
            r_a_col <= i_q_col;
        end
        if (a_adv && emit) begin
            r_o_pix  <= res ? FG_VALUE : 8'd0;
            r_o_last <= r_a_ctl.last;
        end
    end

endmodule
